>>> rtl/core/worst_fit_hole_allocator_defines.svh
// Assertion macros for the worst-fit hole allocator
`ifndef WORST_FIT_HOLE_ALLOCATOR_DEFINES_SVH
`define WORST_FIT_HOLE_ALLOCATOR_DEFINES_SVH

// Property must hold at every clock edge outside reset
`define WFHA_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen outside reset
`define WFHA_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/core/wfha_pkg.sv
// Shared types and constants for the worst-fit hole allocator
package wfha_pkg;

  localparam int MAX_HOLES = 16;
  localparam int ADDR_BITS = 16;
  localparam int IDX_W     = $clog2(MAX_HOLES);
  localparam int CNT_W     = $clog2(MAX_HOLES + 1);
  localparam int HOLE_W    = 2 * ADDR_BITS;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef struct packed {
    addr_t start;
    addr_t len;
  } hole_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NO_FIT = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    hole_t            wr_data;
    logic [IDX_W-1:0] rd_addr;
  } mem_req_t;

endpackage

>>> rtl/core/wfha_ram.sv
// Simple dual-port RAM with registered read data
module wfha_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/wfha_ctrl.sv
// Request sequencer: table scan, update and shift over the hole RAM
module wfha_ctrl import wfha_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     init_req,
  input  addr_t    total_size,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     in_command,
  input  addr_t    in_req_size,
  input  addr_t    in_free_address,
  output mem_req_t mem_req,
  input  hole_t    mem_rdata,
  output logic     res_valid,
  input  logic     res_ready,
  output addr_t    res_address,
  output status_t  res_status
);

  typedef enum logic [6:0] {
    S_INIT   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_SCAN   = 7'b0000100,
    S_DECIDE = 7'b0001000,
    S_SHIFT  = 7'b0010000,
    S_FINAL  = 7'b0100000,
    S_RESP   = 7'b1000000
  } state_t;

  state_t  state_r, state_nxt;
  cnt_t    cnt_r, cnt_nxt;
  logic    cmd_r, cmd_nxt;
  addr_t   size_r, size_nxt;
  addr_t   faddr_r, faddr_nxt;
  cnt_t    i_r, i_nxt;
  logic    rv_r, rv_nxt;
  logic    found_r, found_nxt;
  hole_t   best_r, best_nxt;
  cnt_t    best_idx_r, best_idx_nxt;
  hole_t   cur_r, cur_nxt;
  logic    have_cur_r, have_cur_nxt;
  cnt_t    pos_r, pos_nxt;
  cnt_t    sh_rd_r, sh_rd_nxt;
  cnt_t    sh_left_r, sh_left_nxt;
  logic    sh_up_r, sh_up_nxt;
  logic    pend_r, pend_nxt;
  cnt_t    pend_wa_r, pend_wa_nxt;
  logic    ins_r, ins_nxt;
  addr_t   res_addr_r, res_addr_nxt;
  status_t res_status_r, res_status_nxt;

  cnt_t                 ridx;
  logic                 issue;
  addr_t                newlen;
  logic                 left_touch, right_touch;
  logic [ADDR_BITS:0]   sum_l, sum_r;
  logic [ADDR_BITS+1:0] sum_b;
  addr_t                sat_l, sat_r, sat_b;

  assign ridx   = i_r - cnt_t'(1);
  assign issue  = (i_r < cnt_r);
  assign newlen = best_r.len - size_r;

  assign left_touch  = found_r &&
      (({1'b0, best_r.start} + {1'b0, best_r.len}) == {1'b0, faddr_r});
  assign right_touch = have_cur_r &&
      (({1'b0, faddr_r} + {1'b0, size_r}) == {1'b0, cur_r.start});

  // Merged lengths saturate at all ones
  assign sum_l = {1'b0, best_r.len} + {1'b0, size_r};
  assign sum_r = {1'b0, cur_r.len} + {1'b0, size_r};
  assign sum_b = {2'b00, best_r.len} + {2'b00, size_r} + {2'b00, cur_r.len};
  assign sat_l = sum_l[ADDR_BITS] ? '1 : sum_l[ADDR_BITS-1:0];
  assign sat_r = sum_r[ADDR_BITS] ? '1 : sum_r[ADDR_BITS-1:0];
  assign sat_b = (sum_b[ADDR_BITS+1:ADDR_BITS] != 2'b00) ? '1 : sum_b[ADDR_BITS-1:0];

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    cmd_nxt        = cmd_r;
    size_nxt       = size_r;
    faddr_nxt      = faddr_r;
    i_nxt          = i_r;
    rv_nxt         = 1'b0;
    found_nxt      = found_r;
    best_nxt       = best_r;
    best_idx_nxt   = best_idx_r;
    cur_nxt        = cur_r;
    have_cur_nxt   = have_cur_r;
    pos_nxt        = pos_r;
    sh_rd_nxt      = sh_rd_r;
    sh_left_nxt    = sh_left_r;
    sh_up_nxt      = sh_up_r;
    pend_nxt       = 1'b0;
    pend_wa_nxt    = pend_wa_r;
    ins_nxt        = ins_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    mem_req        = '0;
    mem_req.rd_addr = i_r[IDX_W-1:0];

    case (state_r)
      S_INIT: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = '0;
        mem_req.wr_data = '{start: '0, len: total_size};
        cnt_nxt         = (total_size != '0) ? cnt_t'(1) : '0;
        state_nxt       = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt      = in_command;
          size_nxt     = in_req_size;
          faddr_nxt    = in_free_address;
          i_nxt        = '0;
          found_nxt    = 1'b0;
          have_cur_nxt = 1'b0;
          res_addr_nxt = '0;
          if (in_req_size == '0) begin
            res_status_nxt = (in_command == CMD_FREE) ? ST_OK : ST_NO_FIT;
            state_nxt      = S_RESP;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (issue) begin
          mem_req.rd_addr = i_r[IDX_W-1:0];
          i_nxt           = i_r + cnt_t'(1);
        end
        rv_nxt = issue;
        if (rv_r) begin
          if (cmd_r == CMD_ALLOC) begin
            if (mem_rdata.len >= size_r && (!found_r || mem_rdata.len > best_r.len)) begin
              best_nxt     = mem_rdata;
              best_idx_nxt = ridx;
              found_nxt    = 1'b1;
            end
          end else if (mem_rdata.start <= faddr_r) begin
            best_nxt  = mem_rdata;
            found_nxt = 1'b1;
          end else begin
            // first hole above the freed block: stop here
            cur_nxt      = mem_rdata;
            have_cur_nxt = 1'b1;
            pos_nxt      = ridx;
            rv_nxt       = 1'b0;
            state_nxt    = S_DECIDE;
          end
        end else if (!issue) begin
          pos_nxt   = cnt_r;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        res_addr_nxt   = '0;
        res_status_nxt = ST_OK;
        state_nxt      = S_RESP;
        ins_nxt        = 1'b0;
        if (cmd_r == CMD_ALLOC) begin
          if (!found_r) begin
            res_status_nxt = ST_NO_FIT;
          end else begin
            res_addr_nxt = best_r.start;
            if (newlen != '0) begin
              mem_req.wr_en   = 1'b1;
              mem_req.wr_addr = best_idx_r[IDX_W-1:0];
              mem_req.wr_data = '{start: best_r.start + size_r, len: newlen};
            end else begin
              cnt_nxt     = cnt_r - cnt_t'(1);
              sh_rd_nxt   = best_idx_r + cnt_t'(1);
              sh_left_nxt = cnt_r - cnt_t'(1) - best_idx_r;
              sh_up_nxt   = 1'b0;
              state_nxt   = S_SHIFT;
            end
          end
        end else if (left_touch && right_touch) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = IDX_W'(pos_r - cnt_t'(1));
          mem_req.wr_data = '{start: best_r.start, len: sat_b};
          cnt_nxt     = cnt_r - cnt_t'(1);
          sh_rd_nxt   = pos_r + cnt_t'(1);
          sh_left_nxt = cnt_r - cnt_t'(1) - pos_r;
          sh_up_nxt   = 1'b0;
          state_nxt   = S_SHIFT;
        end else if (left_touch) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = IDX_W'(pos_r - cnt_t'(1));
          mem_req.wr_data = '{start: best_r.start, len: sat_l};
        end else if (right_touch) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = pos_r[IDX_W-1:0];
          mem_req.wr_data = '{start: faddr_r, len: sat_r};
        end else if (cnt_r >= cnt_t'(MAX_HOLES)) begin
          res_status_nxt = ST_FULL;
        end else begin
          // open a slot at pos by moving the upper holes up one
          cnt_nxt     = cnt_r + cnt_t'(1);
          sh_rd_nxt   = cnt_r - cnt_t'(1);
          sh_left_nxt = cnt_r - pos_r;
          sh_up_nxt   = 1'b1;
          ins_nxt     = 1'b1;
          state_nxt   = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (sh_left_r != '0) begin
          mem_req.rd_addr = sh_rd_r[IDX_W-1:0];
          pend_nxt        = 1'b1;
          pend_wa_nxt     = sh_up_r ? sh_rd_r + cnt_t'(1) : sh_rd_r - cnt_t'(1);
          sh_rd_nxt       = sh_up_r ? sh_rd_r - cnt_t'(1) : sh_rd_r + cnt_t'(1);
          sh_left_nxt     = sh_left_r - cnt_t'(1);
        end
        if (pend_r) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = pend_wa_r[IDX_W-1:0];
          mem_req.wr_data = mem_rdata;
        end
        if (sh_left_r == '0 && !pend_r) begin
          state_nxt = ins_r ? S_FINAL : S_RESP;
        end
      end
      S_FINAL: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = pos_r[IDX_W-1:0];
        mem_req.wr_data = '{start: faddr_r, len: size_r};
        state_nxt       = S_RESP;
      end
      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase

    if (init_req) begin
      state_nxt = S_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      cnt_r   <= '0;
      rv_r    <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rv_r    <= rv_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    size_r       <= size_nxt;
    faddr_r      <= faddr_nxt;
    i_r          <= i_nxt;
    found_r      <= found_nxt;
    best_r       <= best_nxt;
    best_idx_r   <= best_idx_nxt;
    cur_r        <= cur_nxt;
    have_cur_r   <= have_cur_nxt;
    pos_r        <= pos_nxt;
    sh_rd_r      <= sh_rd_nxt;
    sh_left_r    <= sh_left_nxt;
    sh_up_r      <= sh_up_nxt;
    pend_wa_r    <= pend_wa_nxt;
    ins_r        <= ins_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
  end

  assign in_ready    = (state_r == S_IDLE);
  assign res_valid   = (state_r == S_RESP);
  assign res_address = res_addr_r;
  assign res_status  = res_status_r;

endmodule

>>> rtl/core/worst_fit_hole_allocator.sv
// Worst-fit hole allocator: one transaction in, one result out per request.
// Allocate scans the hole table, then shifts the upper holes down when a hole empties.
// Free scans up to the first hole above the freed block, then shifts the table for an insert or a merge of both sides.
// Throughput: one request at a time, set by the scan and shift over the hole RAM.
// Reset (and every total_size write) spends one cycle rewriting entry 0 before input opens.
`include "worst_fit_hole_allocator_defines.svh"

module worst_fit_hole_allocator import wfha_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [ADDR_BITS-1:0] cfg_total_size,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_command,
  input  logic [ADDR_BITS-1:0] in_req_size,
  input  logic [ADDR_BITS-1:0] in_free_address,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ADDR_BITS-1:0] out_block_address,
  output logic [1:0]           out_status
);

  addr_t    total_r;
  logic     cfg_fire;
  mem_req_t mem_req;
  logic [HOLE_W-1:0] ram_rdata;
  hole_t    mem_rdata;
  logic     res_valid, res_ready;
  addr_t    res_address;
  status_t  res_status;
  logic     out_valid_r;
  addr_t    out_addr_r;
  status_t  out_status_r;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '1;
    end else if (cfg_fire) begin
      total_r <= cfg_total_size;
    end
  end

  wfha_ram #(
    .DEPTH(MAX_HOLES),
    .WIDTH(HOLE_W)
  ) u_ram (
    .clk  (clk),
    .we   (mem_req.wr_en),
    .waddr(mem_req.wr_addr),
    .wdata(mem_req.wr_data),
    .raddr(mem_req.rd_addr),
    .rdata(ram_rdata)
  );

  assign mem_rdata = hole_t'(ram_rdata);

  wfha_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .init_req       (cfg_fire),
    .total_size     (total_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_req_size    (in_req_size),
    .in_free_address(in_free_address),
    .mem_req        (mem_req),
    .mem_rdata      (mem_rdata),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res_address    (res_address),
    .res_status     (res_status)
  );

  // Output register: take a new result when empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_addr_r   <= res_address;
      out_status_r <= res_status;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_block_address = out_addr_r;
  assign out_status        = out_status_r;

  `WFHA_CHECK(a_cfg_blocks_input, cfg_fire |=> !in_ready, "input open right after config write")
  `WFHA_CHECK(a_err_addr_zero, (out_valid && out_status != ST_OK) |-> (out_block_address == '0), "nonzero address on failed request")
  `WFHA_NEVER(a_bad_status, out_valid && out_status != ST_OK && out_status != ST_NO_FIT && out_status != ST_FULL, "undefined status code")

endmodule

>>> tb/tb_worst_fit_hole_allocator.sv
// Self-checking testbench for the worst-fit hole allocator
module tb_worst_fit_hole_allocator;
  import wfha_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 2 * MAX_HOLES + 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  addr_t cfg_total_size = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_command = CMD_ALLOC;
  addr_t in_req_size = '0;
  addr_t in_free_address = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  addr_t out_block_address;
  logic [1:0] out_status;

  worst_fit_hole_allocator u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_total_size(cfg_total_size),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_req_size(in_req_size), .in_free_address(in_free_address),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_block_address(out_block_address), .out_status(out_status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  typedef struct {
    addr_t addr;
    status_t status;
  } grant_t;

  // Shadow hole table
  int unsigned shadow_start[MAX_HOLES];
  int unsigned shadow_len[MAX_HOLES];
  int unsigned shadow_count;
  grant_t grant_q[$];
  // Outstanding allocations, kept for well-formed frees
  addr_t live_addr[$];
  addr_t live_size[$];

  int errors = 0;
  int cycles = 0;
  int idle_pct = 34;
  int stall_hold = 0;
  bit sender_pause = 1'b0;

  function automatic void table_reset(int unsigned total);
    for (int i = 0; i < MAX_HOLES; i++) begin
      shadow_start[i] = 0;
      shadow_len[i] = 0;
    end
    shadow_len[0] = total;
    shadow_count = (total != 0) ? 1 : 0;
  endfunction

  function automatic void drop_hole(int unsigned idx);
    for (int unsigned i = idx; i + 1 < shadow_count; i++) begin
      shadow_start[i] = shadow_start[i + 1];
      shadow_len[i] = shadow_len[i + 1];
    end
    shadow_count--;
    shadow_start[shadow_count] = 0;
    shadow_len[shadow_count] = 0;
  endfunction

  function automatic int unsigned clamp_len(int unsigned v);
    return (v > 65535) ? 65535 : v;
  endfunction

  function automatic grant_t predict_grant(logic cmd, int unsigned size, int unsigned fa);
    grant_t g;
    int unsigned best, pos;
    bit found, left, right;
    g.addr = '0;
    g.status = ST_OK;
    best = 0;
    found = 0;
    pos = 0;
    if (cmd == CMD_ALLOC) begin
      if (size == 0) begin
        g.status = ST_NO_FIT;
        return g;
      end
      for (int unsigned i = 0; i < shadow_count; i++)
        if (shadow_len[i] >= size && (!found || shadow_len[i] > shadow_len[best])) begin
          best = i;
          found = 1;
        end
      if (!found) begin
        g.status = ST_NO_FIT;
        return g;
      end
      g.addr = shadow_start[best];
      shadow_start[best] = (shadow_start[best] + size) & 16'hFFFF;
      shadow_len[best] -= size;
      if (shadow_len[best] == 0) drop_hole(best);
      return g;
    end
    if (size == 0) return g;
    while (pos < shadow_count && shadow_start[pos] <= fa) pos++;
    left = pos > 0 && shadow_start[pos - 1] + shadow_len[pos - 1] == fa;
    right = pos < shadow_count && fa + size == shadow_start[pos];
    if (left && right) begin
      shadow_len[pos - 1] = clamp_len(shadow_len[pos - 1] + size + shadow_len[pos]);
      drop_hole(pos);
    end else if (left) begin
      shadow_len[pos - 1] = clamp_len(shadow_len[pos - 1] + size);
    end else if (right) begin
      shadow_start[pos] = fa;
      shadow_len[pos] = clamp_len(shadow_len[pos] + size);
    end else if (shadow_count >= MAX_HOLES) begin
      g.status = ST_FULL;
    end else begin
      for (int unsigned i = shadow_count; i > pos; i--) begin
        shadow_start[i] = shadow_start[i - 1];
        shadow_len[i] = shadow_len[i - 1];
      end
      shadow_start[pos] = fa;
      shadow_len[pos] = size;
      shadow_count++;
    end
    return g;
  endfunction

  // Drop valid for each idle cycle
  task automatic idle_gap();
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  // Send one request; a typed row sets the expected result directly
  task automatic send_request(logic cmd, addr_t size, addr_t fa,
                              bit typed = 0, grant_t want = '{addr: '0, status: ST_OK});
    grant_t g;
    idle_gap();
    while (sender_pause) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_req_size <= size;
    in_free_address <= fa;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    g = predict_grant(cmd, size, fa);
    grant_q.push_back(typed ? want : g);
    if (cmd == CMD_ALLOC && g.status == ST_OK) begin
      live_addr.push_back(g.addr);
      live_size.push_back(size);
    end
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (grant_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_total(addr_t value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_total_size <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    table_reset(value);
    live_addr.delete();
    live_size.delete();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic free_live();
    int k;
    k = int'($urandom_range(live_addr.size() - 1));
    send_request(CMD_FREE, live_size[k], live_addr[k]);
    live_addr.delete(k);
    live_size.delete(k);
  endtask

  task automatic random_phase(int count, int unsigned span);
    int unsigned r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 45) send_request(CMD_ALLOC, 16'($urandom_range(span, 1)), 16'($urandom));
      else if (r < 85 && live_addr.size() > 0) free_live();
      else if (r < 92) send_request(1'($urandom_range(1)), 16'($urandom), 16'($urandom));
      else send_request(CMD_FREE, 16'($urandom_range(span, 1)), 16'($urandom));
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    grant_t g;
    if (rst_n && out_valid && out_ready) begin
      if (grant_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transaction: addr %0d status %0d",
                                   out_block_address, out_status);
      end else begin
        g = grant_q.pop_front();
        if (out_block_address !== g.addr || out_status !== g.status) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected addr %0d status %0d, got addr %0d status %0d",
                     g.addr, g.status, out_block_address, out_status);
        end
      end
    end
  end

  // Receiver: random stalls, plus a forced long hold
  always @(negedge clk) begin
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  typedef struct {
    logic cmd;
    addr_t size;
    addr_t fa;
    bit typed;
    addr_t want_addr;
    status_t want_status;
  } row_t;

  row_t rows[$];

  initial begin
    rows = '{
      '{CMD_ALLOC, 16'd0, 16'd0, 1, 16'd0, ST_NO_FIT},        // zero-size allocate
      '{CMD_FREE, 16'd0, 16'd123, 1, 16'd0, ST_OK},           // zero-size free
      '{CMD_ALLOC, 16'd1, 16'hFFFF, 1, 16'd0, ST_OK},
      '{CMD_ALLOC, 16'd100, 16'd0, 1, 16'd1, ST_OK},
      '{CMD_ALLOC, 16'hFFFF, 16'd0, 1, 16'd0, ST_NO_FIT},
      '{CMD_FREE, 16'd1, 16'd0, 0, 16'd0, ST_OK},             // isolated insert
      '{CMD_FREE, 16'd100, 16'd1, 0, 16'd0, ST_OK},           // merge both sides
      '{CMD_ALLOC, 16'hFFFF, 16'd0, 0, 16'd0, ST_OK},         // exact fit empties table
      '{CMD_ALLOC, 16'd1, 16'd0, 1, 16'd0, ST_NO_FIT},
      '{CMD_FREE, 16'd10, 16'd100, 0, 16'd0, ST_OK},
      '{CMD_FREE, 16'd10, 16'd110, 0, 16'd0, ST_OK},          // left merge
      '{CMD_FREE, 16'hFFFF, 16'hFFFF, 0, 16'd0, ST_OK},
      '{CMD_FREE, 16'hFFFF, 16'd0, 0, 16'd0, ST_OK},          // overlaps the holes above
      '{CMD_FREE, 16'd5, 16'd100, 0, 16'd0, ST_OK}            // duplicate start
    };
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    table_reset(65535);
    foreach (rows[i])
      send_request(rows[i].cmd, rows[i].size, rows[i].fa, rows[i].typed,
                   '{rows[i].want_addr, rows[i].want_status});
    // Fill the table with isolated holes until a free reports full
    write_total(16'd0);
    for (int i = 0; i < MAX_HOLES + 2; i++)
      send_request(CMD_FREE, 16'd1, 16'(4 * i + 1), i >= MAX_HOLES, '{16'd0,
                   (i >= MAX_HOLES) ? ST_FULL : ST_OK});
    send_request(CMD_ALLOC, 16'd2, 16'd0, 1, '{16'd0, ST_NO_FIT});
    write_total(16'd1);
    send_request(CMD_ALLOC, 16'd1, 16'd0, 1, '{16'd0, ST_OK});
    // Random phases over several memory sizes
    write_total(16'd64);
    random_phase(150, 12);
    // Long receiver hold while requests keep coming
    write_total(16'hFFFF);
    stall_hold = 300;
    random_phase(150, 8000);
    idle_pct = 0;
    random_phase(100, 40);
    idle_pct = 34;
    sender_pause = 1'b1;
    in_valid <= 1'b0;
    while (grant_q.size() != 0) @(negedge clk);
    sender_pause = 1'b0;
    write_total(16'($urandom_range(65535, 1)));
    random_phase(200, 3000);
    wait_drained();
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
